[hw/rtl/mmfq_pkg.sv]
`default_nettype none

package mmfq_pkg;

  // Default sizing
  localparam int QUEUE_DEPTH_DEF    = 256;
  localparam int KEEP_BYTES_DEF     = 8;
  localparam int CMD_FIFO_DEPTH_DEF = 4;

  // Stream payload widths
  localparam int IN_TDATA_W  = 40;  // data_byte, time_ticks
  localparam int IN_TUSER_W  = 2;   // operation
  localparam int OUT_TDATA_W = 72;  // event fields, zero padded to whole bytes

  // Operation codes carried in the slave-side tuser
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_POLL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // MIDI byte classes
  localparam logic [7:0] STATUS_MIN      = 8'h80;
  localparam logic [7:0] SYSEX_START     = 8'hF0;
  localparam logic [7:0] SYSEX_END       = 8'hF7;
  localparam logic [3:0] CLASS_PROGRAM   = 4'hC;
  localparam logic [3:0] CLASS_PRESSURE  = 4'hD;
  localparam logic [15:0] LENGTH_SAT     = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POLL,
    CMD_CLEAR
  } cmd_kind_t;

  // Per-event bookkeeping kept beside the stored bytes
  typedef struct packed {
    logic        truncated;
    logic [15:0] sysex_length;
    logic [6:0]  byte_count;
    logic [31:0] event_time;
  } info_t;

  localparam int INFO_W = $bits(info_t);

  // Command handed from the parser to the event store
  typedef struct packed {
    cmd_kind_t kind;
    logic      empty;   // poll found the queue empty
    info_t     info;    // valid for pushes
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

`default_nettype wire

[hw/rtl/mmfq_cmd_fifo.sv]
`default_nettype none

module mmfq_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign valid     = (count != '0);
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mmfq_front.sv]
`default_nettype none

module mmfq_front #(
  parameter int QUEUE_DEPTH = mmfq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEEP_BYTES  = mmfq_pkg::KEEP_BYTES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              operation,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    last_in_packet,
  input  wire logic [31:0]             time_ticks,
  input  wire logic                    cmd_full,
  output logic                         cmd_valid,
  output mmfq_pkg::cmd_t               cmd,
  output logic [KEEP_BYTES*8-1:0]      cmd_bytes
);

  import mmfq_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]        build_bytes [KEEP_BYTES];
  logic [15:0]       build_length;
  logic [1:0]        build_expected;
  logic              build_open;
  logic              build_is_sysex;
  logic [FILL_W-1:0] fill;

  logic [7:0]        build_bytes_next [KEEP_BYTES];
  logic [15:0]       build_length_next;
  logic [1:0]        build_expected_next;
  logic              build_open_next;
  logic              build_is_sysex_next;
  logic [FILL_W-1:0] fill_next;

  logic accept;
  logic done;       // message complete on this byte
  logic do_finish;
  logic do_close;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    build_bytes_next    = build_bytes;
    build_length_next   = build_length;
    build_expected_next = build_expected;
    build_open_next     = build_open;
    build_is_sysex_next = build_is_sysex;
    fill_next           = fill;
    done                = 1'b0;
    do_finish           = 1'b0;
    do_close            = 1'b0;
    cmd_valid           = 1'b0;
    cmd                 = '0;
    cmd_bytes           = '0;

    if (accept) begin
      unique case (operation)
        OP_BYTE: begin
          if (build_open || data_byte >= STATUS_MIN) begin
            if (!build_open) begin
              build_length_next   = '0;
              build_expected_next = '0;
              build_is_sysex_next = 1'b0;
            end
            for (int i = 0; i < KEEP_BYTES; i++) begin
              if (build_length_next == 16'(i)) begin
                build_bytes_next[i] = data_byte;
              end
            end
            if (build_length_next != LENGTH_SAT) begin
              build_length_next = build_length_next + 16'd1;
            end

            if (build_open) begin
              if (build_is_sysex) begin
                done = (data_byte == SYSEX_END);
              end else begin
                done = (build_length_next >= {14'd0, build_expected});
              end
            end else if (data_byte == SYSEX_START) begin
              build_open_next     = 1'b1;
              build_is_sysex_next = 1'b1;
            end else if (data_byte >= SYSEX_START) begin
              done = 1'b1;
            end else begin
              build_open_next     = 1'b1;
              build_expected_next = (data_byte[7:4] == CLASS_PROGRAM ||
                                     data_byte[7:4] == CLASS_PRESSURE) ? 2'd2 : 2'd3;
            end
          end

          // packet end: open sysex is flushed, short message dropped
          do_finish = done || (last_in_packet && build_open_next && build_is_sysex_next);
          do_close  = do_finish || (last_in_packet && build_open_next);

          if (do_finish && build_length_next != '0 && fill < FILL_W'(QUEUE_DEPTH)) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_PUSH;
            cmd.info.event_time = time_ticks;
            if (build_length_next > 16'(KEEP_BYTES)) begin
              cmd.info.byte_count = 7'(KEEP_BYTES);
              cmd.info.truncated  = 1'b1;
            end else begin
              cmd.info.byte_count = build_length_next[6:0];
              cmd.info.truncated  = 1'b0;
            end
            cmd.info.sysex_length = build_is_sysex_next ? build_length_next : 16'd0;
            for (int i = 0; i < KEEP_BYTES; i++) begin
              cmd_bytes[i*8 +: 8] = build_bytes_next[i];
            end
            fill_next = fill + 1'b1;
          end

          if (do_close) begin
            build_open_next     = 1'b0;
            build_is_sysex_next = 1'b0;
            build_length_next   = '0;
            build_expected_next = '0;
          end
        end
        OP_POLL: begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_POLL;
          cmd.empty = (fill == '0);
          if (fill != '0) begin
            fill_next = fill - 1'b1;
          end
        end
        OP_CLEAR: begin
          cmd_valid           = 1'b1;
          cmd.kind            = CMD_CLEAR;
          fill_next           = '0;
          build_open_next     = 1'b0;
          build_is_sysex_next = 1'b0;
          build_length_next   = '0;
          build_expected_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    build_bytes <= build_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      build_length   <= '0;
      build_expected <= '0;
      build_open     <= 1'b0;
      build_is_sysex <= 1'b0;
      fill           <= '0;
    end else begin
      build_length   <= build_length_next;
      build_expected <= build_expected_next;
      build_open     <= build_open_next;
      build_is_sysex <= build_is_sysex_next;
      fill           <= fill_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mmfq_back.sv]
`default_nettype none

module mmfq_back #(
  parameter int QUEUE_DEPTH = mmfq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEEP_BYTES  = mmfq_pkg::KEEP_BYTES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cmd_valid,
  input  wire mmfq_pkg::cmd_t          cmd,
  input  wire logic [KEEP_BYTES*8-1:0] cmd_bytes,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         has_event,
  output logic [31:0]                  event_time,
  output logic [7:0]                   raw_byte,
  output logic [5:0]                   byte_index,
  output logic [6:0]                   byte_count,
  output logic [15:0]                  sysex_length,
  output logic                         truncated,
  output logic                         last_result
);

  import mmfq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int IDX_W = $clog2(KEEP_BYTES);
  localparam int ROW_W = KEEP_BYTES * 8 + INFO_W;

  logic [ROW_W-1:0] event_mem [QUEUE_DEPTH];
  logic [ROW_W-1:0] rd_row;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;

  // readout stage
  logic             rd_busy;
  logic             rd_empty;
  logic [IDX_W-1:0] rd_idx;

  info_t            rd_info;
  logic             out_advance;
  logic             rd_last;
  logic             rd_free;
  logic             take_poll;
  logic             take_push;
  logic             take_clear;

  assign rd_info     = info_t'(rd_row[INFO_W-1:0]);
  assign out_advance = !out_valid || out_ready;
  assign rd_last     = rd_empty || ((7'(rd_idx) + 7'd1) == rd_info.byte_count);
  assign rd_free     = !rd_busy || (out_advance && rd_last);

  always_comb begin
    take_poll  = 1'b0;
    take_push  = 1'b0;
    take_clear = 1'b0;
    if (cmd_valid) begin
      unique case (cmd.kind)
        CMD_PUSH:  take_push  = 1'b1;
        CMD_POLL:  take_poll  = rd_free;
        CMD_CLEAR: take_clear = 1'b1;
        default:   take_clear = 1'b0;
      endcase
    end
  end

  assign cmd_pop = take_push || take_poll || take_clear;

  always_ff @(posedge clk) begin
    if (take_push) begin
      event_mem[tail] <= {cmd_bytes, cmd.info};
    end
    if (take_poll) begin
      rd_row <= event_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (take_clear) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (take_push) begin
        tail <= (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (take_poll && !cmd.empty) begin
        head <= (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy  <= 1'b0;
      rd_empty <= 1'b0;
      rd_idx   <= '0;
    end else if (take_poll) begin
      rd_busy  <= 1'b1;
      rd_empty <= cmd.empty;
      rd_idx   <= '0;
    end else if (rd_busy && out_advance) begin
      if (rd_last) begin
        rd_busy <= 1'b0;
        rd_idx  <= '0;
      end else begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= rd_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && rd_busy) begin
      has_event   <= !rd_empty;
      last_result <= rd_last;
      if (rd_empty) begin
        event_time   <= '0;
        raw_byte     <= '0;
        byte_index   <= '0;
        byte_count   <= '0;
        sysex_length <= '0;
        truncated    <= 1'b0;
      end else begin
        event_time   <= rd_info.event_time;
        raw_byte     <= rd_row[INFO_W + 8*rd_idx +: 8];
        byte_index   <= 6'(rd_idx);
        byte_count   <= rd_info.byte_count;
        sysex_length <= rd_info.sysex_length;
        truncated    <= rd_info.truncated;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/midi_message_framer_queue.sv]
// Channel   Dir  Payload
// s_axis    in   tuser = operation, tdata = data_byte + time_ticks, tlast = last_in_packet
// m_axis    out  tuser = has_event, tdata = event fields, tlast = last_result
//
// One input transaction is taken per cycle while the command queue has room;
// packet bytes, polls and clears are all taken at that rate by the parser.
// A poll gives one result per stored byte (1..KEEP_BYTES results), or a single
// result with has_event low when the queue is empty; the next poll's row read overlaps the last byte.
// Reset (rst, synchronous) empties the parser, the command queue and the
// event queue pointers; stored events are not cleared.
// Input stalls only when the command queue is full; output stalls back up
// into the readout stage and then the command queue.
`default_nettype none

module midi_message_framer_queue #(
  parameter int QUEUE_DEPTH = mmfq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEEP_BYTES  = mmfq_pkg::KEEP_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [7:0] data_byte, [39:8] time_ticks
  input  wire logic [mmfq_pkg::IN_TDATA_W-1:0] s_tdata,
  // [1:0] operation
  input  wire logic [mmfq_pkg::IN_TUSER_W-1:0] s_tuser,
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [31:0] event_time, [39:32] raw_byte, [45:40] byte_index,
  // [52:46] byte_count, [68:53] sysex_length, [69] truncated, [71:70] zero
  output logic [mmfq_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // [0] has_event
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  import mmfq_pkg::*;

  localparam int FIFO_W = CMD_W + KEEP_BYTES * 8;

  // parser -> command queue
  logic                    front_valid;
  cmd_t                    front_cmd;
  logic [KEEP_BYTES*8-1:0] front_bytes;
  logic                    fifo_full;

  // command queue -> event store
  logic                    fifo_valid;
  logic [FIFO_W-1:0]       fifo_head;
  logic                    fifo_pop;
  cmd_t                    back_cmd;
  logic [KEEP_BYTES*8-1:0] back_bytes;

  logic [31:0] event_time;
  logic [7:0]  raw_byte;
  logic [5:0]  byte_index;
  logic [6:0]  byte_count;
  logic [15:0] sysex_length;
  logic        truncated;

  mmfq_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEEP_BYTES  (KEEP_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .operation      (s_tuser),
    .data_byte      (s_tdata[7:0]),
    .last_in_packet (s_tlast),
    .time_ticks     (s_tdata[39:8]),
    .cmd_full       (fifo_full),
    .cmd_valid      (front_valid),
    .cmd            (front_cmd),
    .cmd_bytes      (front_bytes)
  );

  mmfq_cmd_fifo #(
    .WIDTH (FIFO_W),
    .DEPTH (CMD_FIFO_DEPTH_DEF)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data ({front_bytes, front_cmd}),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .valid     (fifo_valid),
    .head_data (fifo_head)
  );

  assign back_cmd   = cmd_t'(fifo_head[CMD_W-1:0]);
  assign back_bytes = fifo_head[FIFO_W-1:CMD_W];

  mmfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEEP_BYTES  (KEEP_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (fifo_valid),
    .cmd          (back_cmd),
    .cmd_bytes    (back_bytes),
    .cmd_pop      (fifo_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .has_event    (m_tuser),
    .event_time   (event_time),
    .raw_byte     (raw_byte),
    .byte_index   (byte_index),
    .byte_count   (byte_count),
    .sysex_length (sysex_length),
    .truncated    (truncated),
    .last_result  (m_tlast)
  );

  assign m_tdata = {2'b00, truncated, sysex_length, byte_count, byte_index,
                    raw_byte, event_time};

endmodule

`default_nettype wire

[dv/tb_midi_message_framer_queue.sv]
`timescale 1ns / 1ps

module tb_midi_message_framer_queue;
  import mmfq_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int NBYTES = KEEP_BYTES_DEF;
  // Run guard: ends the run with FAILURE if it has not finished by GUARD_NS
  localparam longint GUARD_NS = 64'd500_000;

  // One queued MIDI message as the framer should hold it
  typedef struct packed {
    logic [31:0]             stamp;
    logic [NBYTES-1:0][7:0]  data;
    logic [6:0]              count;
    logic [15:0]             sx_len;
    logic                    trunc;
  } framed_msg_t;

  // One output transaction of a poll
  typedef struct packed {
    logic        has;
    logic [31:0] stamp;
    logic [7:0]  raw;
    logic [5:0]  idx;
    logic [6:0]  cnt;
    logic [15:0] sx_len;
    logic        trunc;
    logic        last;
  } poll_beat_t;

  // Scoreboard: tracks the parser and event queue, and queues the poll
  // transactions each accepted input should produce.
  class framer_scoreboard;
    logic [NBYTES-1:0][7:0] build_bytes;
    int unsigned            build_len;
    int unsigned            build_need;
    bit                     in_msg;
    bit                     in_sysex;
    framed_msg_t            queued_msgs[$];
    poll_beat_t             expected_beats[$];
    int errors, shown, items, beats;
    int msgs_queued, dropped_full, sysex_msgs, trunc_msgs, sat_msgs, empty_polls;

    function void close_build();
      in_msg     = 0;
      in_sysex   = 0;
      build_len  = 0;
      build_need = 0;
    endfunction

    function void take(logic [7:0] b);
      if (build_len < NBYTES) build_bytes[build_len] = b;
      if (build_len < 65535) build_len++;
    endfunction

    function void finish_msg(logic [31:0] t);
      framed_msg_t m;
      if (build_len > 0 && queued_msgs.size() < QDEPTH) begin
        m.stamp  = t;
        m.data   = build_bytes;
        m.count  = (build_len > NBYTES) ? 7'(NBYTES) : 7'(build_len);
        m.trunc  = build_len > NBYTES;
        m.sx_len = in_sysex ? 16'(build_len) : 16'd0;
        queued_msgs.push_back(m);
        msgs_queued++;
        if (in_sysex) sysex_msgs++;
        if (m.trunc) trunc_msgs++;
        if (in_sysex && m.sx_len == LENGTH_SAT) sat_msgs++;
      end else if (build_len > 0) begin
        dropped_full++;
      end
      close_build();
    endfunction

    // Advance the model by one accepted input transaction
    function void frame_item(logic [1:0] op, logic [7:0] b, logic last, logic [31:0] t);
      framed_msg_t m;
      poll_beat_t  pb;
      items++;
      case (op)
        OP_BYTE: begin
          if (in_msg) begin
            take(b);
            if (in_sysex) begin
              if (b == SYSEX_END) finish_msg(t);
            end else if (build_len >= build_need) begin
              finish_msg(t);
            end
          end else if (b >= STATUS_MIN) begin
            close_build();
            take(b);
            if (b == SYSEX_START) begin
              in_msg   = 1;
              in_sysex = 1;
            end else if (b >= SYSEX_START) begin
              finish_msg(t);  // system common / realtime: single byte
            end else begin
              in_msg     = 1;
              build_need = (b[7:4] == CLASS_PROGRAM || b[7:4] == CLASS_PRESSURE) ? 2 : 3;
            end
          end
          // packet end: open sysex is flushed, short message is dropped
          if (last && in_msg) begin
            if (in_sysex) finish_msg(t);
            else close_build();
          end
        end
        OP_POLL: begin
          if (queued_msgs.size() == 0) begin
            pb      = '0;
            pb.last = 1'b1;
            expected_beats.push_back(pb);
            empty_polls++;
          end else begin
            m = queued_msgs.pop_front();
            for (int k = 0; k < m.count; k++) begin
              pb.has    = 1'b1;
              pb.stamp  = m.stamp;
              pb.raw    = m.data[k];
              pb.idx    = 6'(k);
              pb.cnt    = m.count;
              pb.sx_len = m.sx_len;
              pb.trunc  = m.trunc;
              pb.last   = (k + 1 == m.count);
              expected_beats.push_back(pb);
            end
          end
        end
        OP_CLEAR: begin
          queued_msgs.delete();
          close_build();
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        shown++;
        if (shown <= 200)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] d, logic u, logic l);
      poll_beat_t w;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual tdata=%h tuser=%b",
                 $time, d, u);
        return;
      end
      w = expected_beats.pop_front();
      beats++;
      cmp("has_event",     32'(w.has),    32'(u));
      cmp("event_time",    w.stamp,       d[31:0]);
      cmp("raw_byte",      32'(w.raw),    32'(d[39:32]));
      cmp("byte_index",    32'(w.idx),    32'(d[45:40]));
      cmp("byte_count",    32'(w.cnt),    32'(d[52:46]));
      cmp("sysex_length",  32'(w.sx_len), 32'(d[68:53]));
      cmp("truncated",     32'(w.trunc),  32'(d[69]));
      cmp("tdata padding", 32'd0,         32'(d[71:70]));
      cmp("last_result",   32'(w.last),   32'(l));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte, [39:8] time_ticks
  logic [IN_TUSER_W-1:0]  s_tuser = '0;   // [1:0] operation
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // event_time, raw_byte, byte_index, count, sx len, trunc
  logic                   m_tuser;        // [0] has_event
  logic                   m_tlast;

  framer_scoreboard sb = new();
  logic [31:0] now_ticks = '0;

  always #5 clk = ~clk;

  midi_message_framer_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .KEEP_BYTES (NBYTES)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // Relative time mostly creeps forward, now and then jumps anywhere
  function automatic logic [31:0] stamp();
    if ($urandom_range(0, 15) == 0) now_ticks = $urandom;
    else now_ticks += $urandom_range(0, 2000);
    return now_ticks;
  endfunction

  // Present one transaction and hold it until accepted. tvalid stays high
  // across back-to-back items; it only drops for a drawn gap.
  task automatic put_item(input logic [1:0] op, input logic [7:0] b, input logic last,
                          input logic [31:0] t);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {t, b};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.frame_item(op, b, last, t);
  endtask

  task automatic byte_in(input logic [7:0] b, input logic last);
    put_item(OP_BYTE, b, last, stamp());
  endtask

  task automatic poll();
    put_item(OP_POLL, 8'($urandom), 1'($urandom_range(0, 1)), stamp());
  endtask

  // Mostly well-formed messages with random content; some broken packets,
  // stray bytes, polls and clears mixed in.
  task automatic random_traffic(input int goal);
    int done, kind, len;
    logic [7:0] st;
    bit cut;
    done = 0;
    while (done < goal) begin
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        // channel voice message, sometimes cut short by a packet end
        st  = 8'($urandom_range(8'h80, 8'hEF));
        len = (st[7:4] == CLASS_PROGRAM || st[7:4] == CLASS_PRESSURE) ? 2 : 3;
        cut = ($urandom_range(0, 5) == 0);
        if (cut) len = $urandom_range(1, len - 1);
        for (int k = 0; k < len; k++)
          byte_in((k == 0) ? st :
                  ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8'h7F)),
                  (k == len - 1) && (cut || $urandom_range(0, 1) == 1));
        done += len;
      end else if (kind < 8) begin
        byte_in(8'($urandom_range(8'hF1, 8'hFF)), 1'($urandom_range(0, 1)));
        done++;
      end else if (kind < 10) begin
        // sysex; short ones mostly, a few past the stored width
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 10);
        byte_in(SYSEX_START, 1'b0);
        for (int k = 0; k < len; k++)
          byte_in(8'($urandom_range(0, 8'hF6)), $urandom_range(0, 39) == 0);
        if ($urandom_range(0, 3) == 0) byte_in(8'($urandom_range(0, 8'h7F)), 1'b1);
        else byte_in(SYSEX_END, 1'($urandom_range(0, 1)));
        done += len + 2;
      end else if (kind < 12) begin
        // stray byte; usually skipped, so not counted
        byte_in(8'($urandom), 1'($urandom_range(0, 1)));
      end else if (kind < 19) begin
        poll();
        done++;
      end else begin
        put_item(OP_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)), stamp());
        done++;
      end
    end
  endtask

  // Output side: random stall before each result
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_beat(m_tdata, m_tuser, m_tlast);
    end
  end

  initial begin
    #(GUARD_NS);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty poll, each message class, stray data, in-message status
    // values, packet-end drop and sysex flush, time extremes
    poll();
    byte_in(8'h90, 1'b0); byte_in(8'h3C, 1'b0); put_item(OP_BYTE, 8'h7F, 1'b0, 32'd0);
    byte_in(8'hC5, 1'b0); byte_in(8'h12, 1'b0);
    byte_in(8'hDF, 1'b0); byte_in(8'h00, 1'b1);
    byte_in(8'h40, 1'b0);
    byte_in(8'h80, 1'b0); byte_in(8'hFF, 1'b0); byte_in(8'h00, 1'b0);
    put_item(OP_BYTE, 8'hF8, 1'b1, 32'hFFFF_FFFF);
    byte_in(SYSEX_START, 1'b0); byte_in(8'h01, 1'b0); byte_in(8'h02, 1'b0);
    byte_in(SYSEX_END, 1'b0);
    byte_in(8'hB0, 1'b0); byte_in(8'h07, 1'b1);
    byte_in(SYSEX_START, 1'b0); byte_in(8'h7E, 1'b1);
    byte_in(SYSEX_END, 1'b0);
    repeat (8) poll();

    random_traffic(80);

    s_tvalid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run: %0d input transactions, %0d results checked, %0d empty polls",
             sb.items, sb.beats, sb.empty_polls);
    $display("Messages: %0d queued, %0d lost to a full queue, %0d sysex (%0d cut, %0d sat)",
             sb.msgs_queued, sb.dropped_full, sb.sysex_msgs, sb.trunc_msgs, sb.sat_msgs);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mmfq_pkg.sv
hw/rtl/mmfq_cmd_fifo.sv
hw/rtl/mmfq_front.sv
hw/rtl/mmfq_back.sv
hw/rtl/midi_message_framer_queue.sv
dv/tb_midi_message_framer_queue.sv
